// ===== sv/integer_to_text_formatter_assert.svh =====
// Assertion macros shared by the integer-to-text formatter RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef INTEGER_TO_TEXT_FORMATTER_ASSERT_SVH
`define INTEGER_TO_TEXT_FORMATTER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define ITF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent
`define ITF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/itf_pkg.sv =====
// Package for the integer-to-text formatter: sizes, character codes,
// controller states and the command/status bundles. No dependencies.
`default_nettype none

package itf_pkg;

   // Sizing
   localparam int VALUE_BITS = 32;
   localparam int MAX_CHARS  = 64;
   localparam int PREC_MAX   = MAX_CHARS - 3;

   // Input field widths
   localparam int RADIX_W = 6;
   localparam int FW_W    = 7;
   localparam int PREC_W  = 6;
   localparam int CHAR_W  = 8;

   // Divider: DIV_STEP quotient bits per cycle
   localparam int DIV_STEP   = 4;
   localparam int DIV_BITS   = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
   localparam int DIV_CYCLES = DIV_BITS / DIV_STEP;
   localparam int DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_CYCLES - 1);

   // Digit count and text position widths
   localparam int ND_W  = $clog2(VALUE_BITS + 1);
   localparam int LEN_W = $clog2(MAX_CHARS + VALUE_BITS + 4);

   // Radix limits and bases that take a prefix
   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_OCT = RADIX_W'(8);
   localparam logic [RADIX_W-1:0] RADIX_HEX = RADIX_W'(16);

   // Digit set index of the hex prefix letter
   localparam logic [RADIX_W-1:0] X_INDEX = RADIX_W'(33);

   // Character codes
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PREC,
      ST_PAD,
      ST_BOUND,
      ST_EMIT,
      ST_ERR
   } itf_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic div_run;
      logic setup_prec;
      logic setup_pad;
      logic setup_bound;
      logic emit;
      logic emit_err;
   } itf_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic bad_radix;
      logic digit_done;
      logic quo_zero;
      logic slot_free;
      logic last_pos;
   } itf_status_type;

   // Digit value 0..35 to ASCII, lower or upper case letters above 9
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] dx;
      dx = CHAR_W'(d);
      if (d < RADIX_W'(10))
         return CH_ZERO + dx;
      else
         return (upper ? CH_UA : CH_LA) + dx - CHAR_W'(10);
   endfunction

endpackage

`default_nettype wire

// ===== sv/itf_ctrl.sv =====
// Controller state machine of the integer-to-text formatter.
// Depends on itf_pkg and the assertion macro header.
`default_nettype none

`include "integer_to_text_formatter_assert.svh"

module itf_ctrl
   import itf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire itf_status_type status,
   output itf_cmd_type         cmd
);

   itf_state_type state_ff;
   itf_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.bad_radix ? ST_ERR : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.digit_done && status.quo_zero) begin
               state_in = ST_PREC;
            end
         end
         ST_PREC:  state_in = ST_PAD;
         ST_PAD:   state_in = ST_BOUND;
         ST_BOUND: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.slot_free && status.last_pos) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIVIDE: cmd.div_run     = 1'b1;
         ST_PREC:   cmd.setup_prec  = 1'b1;
         ST_PAD:    cmd.setup_pad   = 1'b1;
         ST_BOUND:  cmd.setup_bound = 1'b1;
         ST_EMIT:   cmd.emit        = 1'b1;
         ST_ERR:    cmd.emit_err    = 1'b1;
         default:   cmd             = '0;
      endcase
   end

   `ITF_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != ST_IDLE,
                    "transfer accepted but controller stayed idle")
   `ITF_ASSERT_NEXT(a_divide_holds, state_ff == ST_DIVIDE && !status.digit_done,
                    state_ff == ST_DIVIDE, "left divide before digit was complete")
   `ITF_ASSERT_NEXT(a_err_waits_slot, state_ff == ST_ERR && !status.slot_free,
                    state_ff == ST_ERR, "error result dropped while output busy")

endmodule

`default_nettype wire

// ===== sv/itf_dpath.sv =====
// Datapath of the integer-to-text formatter: operand capture, radix divider,
// digit stack, text layout and the output register. Depends on itf_pkg.
`default_nettype none

`include "integer_to_text_formatter_assert.svh"

module itf_dpath
   import itf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire logic [RADIX_W-1:0]    req_radix,
   input  wire logic [FW_W-1:0]       req_min_width,
   input  wire logic [PREC_W-1:0]     req_min_digits,
   input  wire logic                  req_zero_pad,
   input  wire logic                  req_signed_mode,
   input  wire logic                  req_show_plus,
   input  wire logic                  req_space_sign,
   input  wire logic                  req_left_justify,
   input  wire logic                  req_alt_prefix,
   input  wire logic                  req_upper_case,
   input  wire itf_cmd_type           cmd,
   output itf_status_type             status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [CHAR_W-1:0]          rsp_out_char,
   output logic                       rsp_last_char,
   output logic                       rsp_bad_radix
);

   // Captured item
   logic [RADIX_W-1:0]  base_ff;
   logic [LEN_W-1:0]    width_ff;
   logic [LEN_W-1:0]    prec_ff;
   logic [1:0]          pfx_ff;
   logic                sign_ff;
   logic [CHAR_W-1:0]   sign_char_ff;
   logic                zpad_ff;
   logic                left_ff;
   logic                upper_ff;

   // Divider and digit stack
   logic [DIV_BITS-1:0] quo_ff;
   logic [RADIX_W-1:0]  rem_ff;
   logic [DCNT_W-1:0]   dcnt_ff;
   logic [ND_W-1:0]     nd_ff;
   logic [RADIX_W-1:0]  digs_ff [VALUE_BITS];

   // Layout
   logic [LEN_W-1:0]    pad_ff;
   logic [LEN_W-1:0]    e_lead_ff;
   logic [LEN_W-1:0]    e_sign_ff;
   logic [LEN_W-1:0]    e_pfx_ff;
   logic [LEN_W-1:0]    e_zero_ff;
   logic [LEN_W-1:0]    e_dig_ff;
   logic [LEN_W-1:0]    e_last_ff;
   logic [LEN_W-1:0]    pos_ff;

   // Output register
   logic                rsp_valid_ff;
   logic [CHAR_W-1:0]   rsp_out_char_ff;
   logic                rsp_last_char_ff;
   logic                rsp_bad_radix_ff;

   // Combinational helpers
   logic [VALUE_BITS-1:0] mag;
   logic                  neg;
   logic [RADIX_W:0]      div_t;
   logic [RADIX_W-1:0]    div_r;
   logic [DIV_BITS-1:0]   div_q;
   logic [LEN_W:0]        pad_diff;
   logic [LEN_W-1:0]      nd_ext;
   logic [LEN_W-1:0]      lead_n;
   logic [LEN_W-1:0]      zpad_n;
   logic [LEN_W-1:0]      trail_n;
   logic [LEN_W-1:0]      b_lead;
   logic [LEN_W-1:0]      b_sign;
   logic [LEN_W-1:0]      b_pfx;
   logic [LEN_W-1:0]      b_zero;
   logic [LEN_W-1:0]      b_dig;
   logic [LEN_W-1:0]      b_total;
   logic [CHAR_W-1:0]     cur_char;
   logic                  in_digits;
   logic                  slot_free;
   logic                  emit_go;

   assign neg = req_signed_mode & req_value[VALUE_BITS-1];
   assign mag = neg ? (~req_value + VALUE_BITS'(1)) : req_value;
   assign nd_ext = LEN_W'(nd_ff);

   // Capture the item and its flags
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff  <= req_radix;
         width_ff <= (req_min_width > FW_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS)
                                                         : LEN_W'(req_min_width);
         prec_ff  <= (req_min_digits > PREC_W'(PREC_MAX)) ? LEN_W'(PREC_MAX)
                                                          : LEN_W'(req_min_digits);
         sign_ff  <= req_signed_mode & (neg | req_show_plus | req_space_sign);
         sign_char_ff <= neg ? CH_MINUS : (req_show_plus ? CH_PLUS : CH_SPACE);
         if (req_alt_prefix && req_radix == RADIX_HEX)
            pfx_ff <= 2'd2;
         else if (req_alt_prefix && req_radix == RADIX_OCT)
            pfx_ff <= 2'd1;
         else
            pfx_ff <= 2'd0;
         zpad_ff  <= req_zero_pad & ~req_left_justify;
         left_ff  <= req_left_justify;
         upper_ff <= req_upper_case;
      end else if (cmd.setup_prec) begin
         if (prec_ff < nd_ext)
            prec_ff <= nd_ext;
      end
   end

   // Restoring division, DIV_STEP quotient bits per cycle
   always_comb begin
      div_r = rem_ff;
      div_q = quo_ff;
      div_t = '0;
      for (int k = 0; k < DIV_STEP; k++) begin
         div_t = {div_r, div_q[DIV_BITS-1]};
         div_q = {div_q[DIV_BITS-2:0], 1'b0};
         if (div_t >= {1'b0, base_ff}) begin
            div_r    = RADIX_W'(div_t - {1'b0, base_ff});
            div_q[0] = 1'b1;
         end else begin
            div_r = div_t[RADIX_W-1:0];
         end
      end
   end

   assign status.digit_done = (dcnt_ff == DCNT_LAST);
   assign status.quo_zero   = (div_q == '0);
   assign status.bad_radix  = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX);

   // Divider registers and digit counter
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quo_ff  <= DIV_BITS'(mag);
         rem_ff  <= '0;
         dcnt_ff <= '0;
         nd_ff   <= '0;
      end else if (cmd.div_run) begin
         quo_ff <= div_q;
         if (status.digit_done) begin
            rem_ff  <= '0;
            dcnt_ff <= '0;
            nd_ff   <= nd_ff + ND_W'(1);
         end else begin
            rem_ff  <= div_r;
            dcnt_ff <= dcnt_ff + DCNT_W'(1);
         end
      end
   end

   // Digit stack: least significant digit pushed first, popped most significant first
   always_ff @(posedge clock) begin
      if (cmd.div_run && status.digit_done) begin
         digs_ff[0] <= div_r;
         for (int i = 1; i < VALUE_BITS; i++)
            digs_ff[i] <= digs_ff[i-1];
      end else if (emit_go && in_digits) begin
         for (int i = 0; i < VALUE_BITS - 1; i++)
            digs_ff[i] <= digs_ff[i+1];
         digs_ff[VALUE_BITS-1] <= '0;
      end
   end

   // Padding amount, clamped at zero
   assign pad_diff = {1'b0, width_ff} - {1'b0, prec_ff}
                     - (LEN_W+1)'(pfx_ff) - (LEN_W+1)'(sign_ff);

   // Segment boundaries of the text
   assign lead_n  = (!zpad_ff && !left_ff) ? pad_ff : '0;
   assign zpad_n  = zpad_ff ? pad_ff : '0;
   assign trail_n = left_ff ? pad_ff : '0;
   assign b_lead  = lead_n;
   assign b_sign  = b_lead + LEN_W'(sign_ff);
   assign b_pfx   = b_sign + LEN_W'(pfx_ff);
   assign b_zero  = b_pfx + zpad_n + (prec_ff - nd_ext);
   assign b_dig   = b_zero + nd_ext;
   assign b_total = b_dig + trail_n;

   always_ff @(posedge clock) begin
      if (cmd.setup_pad) begin
         pad_ff <= pad_diff[LEN_W] ? '0 : pad_diff[LEN_W-1:0];
      end
      if (cmd.setup_bound) begin
         e_lead_ff <= b_lead;
         e_sign_ff <= b_sign;
         e_pfx_ff  <= b_pfx;
         e_zero_ff <= b_zero;
         e_dig_ff  <= b_dig;
         e_last_ff <= b_total - LEN_W'(1);
      end
   end

   // Character at the current text position
   always_comb begin
      in_digits = 1'b0;
      if (pos_ff < e_lead_ff)
         cur_char = CH_SPACE;
      else if (pos_ff < e_sign_ff)
         cur_char = sign_char_ff;
      else if (pos_ff < e_pfx_ff)
         cur_char = (pos_ff == e_sign_ff) ? CH_ZERO : digit_char(X_INDEX, upper_ff);
      else if (pos_ff < e_zero_ff)
         cur_char = CH_ZERO;
      else if (pos_ff < e_dig_ff) begin
         cur_char  = digit_char(digs_ff[0], upper_ff);
         in_digits = 1'b1;
      end else
         cur_char = CH_SPACE;
   end

   assign slot_free        = ~rsp_valid_ff | rsp_ready;
   assign emit_go          = cmd.emit & slot_free;
   assign status.slot_free = slot_free;
   assign status.last_pos  = (pos_ff == e_last_ff) || (pos_ff == LEN_W'(MAX_CHARS - 1));

   // Text position
   always_ff @(posedge clock) begin
      if (cmd.load)
         pos_ff <= '0;
      else if (emit_go)
         pos_ff <= pos_ff + LEN_W'(1);
   end

   // Output register, refilled in the cycle its transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go || (cmd.emit_err && slot_free)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_out_char_ff  <= cur_char;
         rsp_last_char_ff <= status.last_pos;
         rsp_bad_radix_ff <= 1'b0;
      end else if (cmd.emit_err && slot_free) begin
         rsp_out_char_ff  <= CH_NUL;
         rsp_last_char_ff <= 1'b1;
         rsp_bad_radix_ff <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_out_char_ff;
   assign rsp_last_char = rsp_last_char_ff;
   assign rsp_bad_radix = rsp_bad_radix_ff;

   `ITF_ASSERT_NOW(a_err_result_form, rsp_valid_ff && rsp_bad_radix_ff,
                   rsp_last_char_ff && rsp_out_char_ff == CH_NUL,
                   "bad radix result is not a single null character")
   `ITF_ASSERT_NOW(a_stack_bound, cmd.div_run && status.digit_done,
                   nd_ff < ND_W'(VALUE_BITS), "digit stack overflow")

endmodule

`default_nettype wire

// ===== sv/integer_to_text_formatter.sv =====
// Integer-to-text formatter: turns one value with radix, width, precision and
// flags into printf-style ASCII text, one character per rsp transfer, with the
// final character flagged by rsp_last_char. An item occupies the block from
// acceptance through division, setup of precision, padding and boundaries,
// and emission of its text; a new request is taken only when idle. Digits
// come from a shared restoring divider that retires 4 quotient bits per
// cycle, one digit at a time, and the text leaves at one character per
// cycle while the output does not stall. A radix outside 2..36 yields one
// null character with rsp_bad_radix set.
// Depends on itf_pkg, itf_ctrl and itf_dpath.
`default_nettype none

module integer_to_text_formatter
   import itf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire logic [RADIX_W-1:0]    req_radix,
   input  wire logic [FW_W-1:0]       req_min_width,
   input  wire logic [PREC_W-1:0]     req_min_digits,
   input  wire logic                  req_zero_pad,
   input  wire logic                  req_signed_mode,
   input  wire logic                  req_show_plus,
   input  wire logic                  req_space_sign,
   input  wire logic                  req_left_justify,
   input  wire logic                  req_alt_prefix,
   input  wire logic                  req_upper_case,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [CHAR_W-1:0]          rsp_out_char,
   output logic                       rsp_last_char,
   output logic                       rsp_bad_radix
);

   itf_cmd_type    cmd;
   itf_status_type status;

   // Sequencer
   itf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Divider, layout and output register
   itf_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .req_radix        (req_radix),
      .req_min_width    (req_min_width),
      .req_min_digits   (req_min_digits),
      .req_zero_pad     (req_zero_pad),
      .req_signed_mode  (req_signed_mode),
      .req_show_plus    (req_show_plus),
      .req_space_sign   (req_space_sign),
      .req_left_justify (req_left_justify),
      .req_alt_prefix   (req_alt_prefix),
      .req_upper_case   (req_upper_case),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_char    (rsp_last_char),
      .rsp_bad_radix    (rsp_bad_radix)
   );

endmodule

`default_nettype wire

// ===== verif/integer_to_text_formatter_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for integer_to_text_formatter: directed corner cases, then
// random printf-style requests under random handshake gaps. Needs itf_pkg.

import itf_pkg::*;

typedef struct packed {
   logic [VALUE_BITS-1:0] value;
   logic [RADIX_W-1:0]    radix;
   logic [FW_W-1:0]       min_width;
   logic [PREC_W-1:0]     min_digits;
   logic                  zero_pad;
   logic                  signed_mode;
   logic                  show_plus;
   logic                  space_sign;
   logic                  left_justify;
   logic                  alt_prefix;
   logic                  upper_case;
} fmt_req_type;

typedef struct packed {
   logic [CHAR_W-1:0] ch;
   logic              last;
   logic              bad;
} text_char_type;

// Renders each accepted request into the characters it must produce and
// matches arriving characters against them in order.
class format_text_check;
   text_char_type pending_chars[$];
   int errors;
   int requests;
   int bad_requests;
   int chars_seen;
   int longest;

   function logic [CHAR_W-1:0] digit_ascii(int d, bit upper);
      if (d < 10)
         return CH_ZERO + CHAR_W'(d);
      return (upper ? CH_UA : CH_LA) + CHAR_W'(d - 10);
   endfunction

   function void note_request(fmt_req_type r);
      logic [VALUE_BITS-1:0] mag;
      logic [VALUE_BITS-1:0] base;
      logic [CHAR_W-1:0]     sign_ch;
      logic [CHAR_W-1:0]     digit_buf[$];
      logic [CHAR_W-1:0]     text[$];
      text_char_type         res;
      int width, prec, pfx, pad, count;
      bit zpad, has_sign;

      requests++;
      // Out-of-range base: one null character flagged as bad
      if (r.radix < RADIX_MIN || r.radix > RADIX_MAX) begin
         bad_requests++;
         res.ch   = CH_NUL;
         res.last = 1'b1;
         res.bad  = 1'b1;
         pending_chars.push_back(res);
         return;
      end

      width = (int'(r.min_width) > MAX_CHARS) ? MAX_CHARS : int'(r.min_width);
      prec  = (int'(r.min_digits) > PREC_MAX) ? PREC_MAX : int'(r.min_digits);
      zpad  = r.zero_pad && !r.left_justify;
      mag   = r.value;
      base  = VALUE_BITS'(r.radix);

      // Sign character, signed mode only
      has_sign = 1'b0;
      sign_ch  = CH_SPACE;
      if (r.signed_mode) begin
         if (r.value[VALUE_BITS-1]) begin
            has_sign = 1'b1;
            sign_ch  = CH_MINUS;
            mag      = ~r.value + 1'b1;
         end else if (r.show_plus) begin
            has_sign = 1'b1;
            sign_ch  = CH_PLUS;
         end else if (r.space_sign) begin
            has_sign = 1'b1;
            sign_ch  = CH_SPACE;
         end
      end

      pfx = 0;
      if (r.alt_prefix) begin
         if (r.radix == RADIX_HEX)
            pfx = 2;
         else if (r.radix == RADIX_OCT)
            pfx = 1;
      end

      // Digits, most significant first
      if (mag == '0)
         digit_buf.push_back(CH_ZERO);
      while (mag != '0) begin
         digit_buf.push_front(digit_ascii(int'(mag % base), r.upper_case));
         mag = mag / base;
      end
      if (prec < digit_buf.size())
         prec = digit_buf.size();

      pad = width - prec - pfx - (has_sign ? 1 : 0);
      if (pad < 0)
         pad = 0;

      // Assemble the text in printf order
      if (!zpad && !r.left_justify)
         repeat (pad) text.push_back(CH_SPACE);
      if (has_sign)
         text.push_back(sign_ch);
      if (pfx >= 1)
         text.push_back(CH_ZERO);
      if (pfx == 2)
         text.push_back(digit_ascii(int'(X_INDEX), r.upper_case));
      if (zpad)
         repeat (pad) text.push_back(CH_ZERO);
      repeat (prec - digit_buf.size()) text.push_back(CH_ZERO);
      foreach (digit_buf[i])
         text.push_back(digit_buf[i]);
      if (r.left_justify)
         repeat (pad) text.push_back(CH_SPACE);

      count = (text.size() > MAX_CHARS) ? MAX_CHARS : text.size();
      if (count > longest)
         longest = count;
      for (int i = 0; i < count; i++) begin
         res.ch   = text[i];
         res.last = (i == count - 1);
         res.bad  = 1'b0;
         pending_chars.push_back(res);
      end
   endfunction

   function void check_char(logic [CHAR_W-1:0] ch, logic last, logic bad);
      text_char_type want;

      chars_seen++;
      if (pending_chars.size() == 0) begin
         $display("%0t: char %h last %b bad %b arrived, expected none", $time, ch, last, bad);
         errors++;
         return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch) begin
         $display("%0t: out_char expected %h actual %h", $time, want.ch, ch);
         errors++;
      end
      if (last !== want.last) begin
         $display("%0t: last_char expected %b actual %b", $time, want.last, last);
         errors++;
      end
      if (bad !== want.bad) begin
         $display("%0t: bad_radix expected %b actual %b", $time, want.bad, bad);
         errors++;
      end
   endfunction

   function int outstanding();
      return pending_chars.size();
   endfunction
endclass

module integer_to_text_formatter_test;

   localparam int CLK_PERIOD   = 10;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE_WAIT  = 350;
   localparam int PHASE_ITEMS  = 97;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [VALUE_BITS-1:0] req_value;
   logic [RADIX_W-1:0]    req_radix;
   logic [FW_W-1:0]       req_min_width;
   logic [PREC_W-1:0]     req_min_digits;
   logic                  req_zero_pad;
   logic                  req_signed_mode;
   logic                  req_show_plus;
   logic                  req_space_sign;
   logic                  req_left_justify;
   logic                  req_alt_prefix;
   logic                  req_upper_case;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [CHAR_W-1:0]     rsp_out_char;
   logic                  rsp_last_char;
   logic                  rsp_bad_radix;

   format_text_check ledger = new();

   bit tx_quiet;
   bit rx_quiet;
   bit rx_hold_req;
   int idle_cycles;

   integer_to_text_formatter dut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         ledger.check_char(rsp_out_char, rsp_last_char, rsp_bad_radix);
   end

   // Watchdog: consecutive cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Receiver: random wait before each character, one long hold on request
   initial begin
      int gap;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         gap = rx_quiet ? 0 : $urandom_range(0, 9);
         if (rx_hold_req) begin
            gap = HOLD_CYCLES;
            rx_hold_req = 1'b0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Offer one request; returns on the falling edge after its transfer
   task automatic send_item(input fmt_req_type r);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_value        <= r.value;
      req_radix        <= r.radix;
      req_min_width    <= r.min_width;
      req_min_digits   <= r.min_digits;
      req_zero_pad     <= r.zero_pad;
      req_signed_mode  <= r.signed_mode;
      req_show_plus    <= r.show_plus;
      req_space_sign   <= r.space_sign;
      req_left_justify <= r.left_justify;
      req_alt_prefix   <= r.alt_prefix;
      req_upper_case   <= r.upper_case;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      ledger.note_request(r);
      @(negedge clock);
   endtask

   // Stop offering and wait for every pending character
   task automatic drain_text();
      req_valid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic fmt_req_type make_req(logic [VALUE_BITS-1:0] value,
                                            int radix, int fw, int md,
                                            logic [6:0] flags);
      fmt_req_type r;
      r.value = value;
      r.radix = RADIX_W'(radix);
      r.min_width = FW_W'(fw);
      r.min_digits = PREC_W'(md);
      {r.zero_pad, r.signed_mode, r.show_plus, r.space_sign,
       r.left_justify, r.alt_prefix, r.upper_case} = flags;
      return r;
   endfunction

   // Random request: small widths mostly, common bases favored
   function automatic fmt_req_type random_req();
      fmt_req_type r;
      int pick;
      pick = $urandom_range(0, 5);
      case (pick)
         0: r.value = $urandom;
         1: r.value = $urandom_range(0, 99);
         2: r.value = -$urandom_range(1, 99);
         3: begin
            case ($urandom_range(0, 4))
               0: r.value = '0;
               1: r.value = '1;
               2: r.value = {1'b1, {(VALUE_BITS-1){1'b0}}};
               3: r.value = {1'b0, {(VALUE_BITS-1){1'b1}}};
               default: r.value = 1;
            endcase
         end
         default: r.value = $urandom >> $urandom_range(0, VALUE_BITS - 1);
      endcase
      pick = $urandom_range(0, 19);
      case (pick)
         0: r.radix = RADIX_W'($urandom_range(0, 63));
         1: r.radix = RADIX_W'($urandom_range(37, 63));
         2, 3, 4, 5: r.radix = RADIX_W'(10);
         6, 7, 8: r.radix = RADIX_HEX;
         9, 10: r.radix = RADIX_OCT;
         11: r.radix = RADIX_MIN;
         12: r.radix = RADIX_MAX;
         default: r.radix = RADIX_W'($urandom_range(2, 36));
      endcase
      r.min_width = ($urandom_range(0, 9) == 0) ? FW_W'($urandom_range(0, 127))
                                                : FW_W'($urandom_range(0, 16));
      r.min_digits = ($urandom_range(0, 9) == 0) ? PREC_W'($urandom_range(0, 63))
                                                 : PREC_W'($urandom_range(0, 12));
      {r.zero_pad, r.signed_mode, r.show_plus, r.space_sign,
       r.left_justify, r.alt_prefix, r.upper_case} = 7'($urandom);
      return r;
   endfunction

   // Flag order: zero_pad signed show_plus space left alt upper
   initial begin
      fmt_req_type directed[$];

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_value        = '0;
      req_radix        = '0;
      req_min_width    = '0;
      req_min_digits   = '0;
      req_zero_pad     = 1'b0;
      req_signed_mode  = 1'b0;
      req_show_plus    = 1'b0;
      req_space_sign   = 1'b0;
      req_left_justify = 1'b0;
      req_alt_prefix   = 1'b0;
      req_upper_case   = 1'b0;
      tx_quiet         = 1'b0;
      rx_quiet         = 1'b0;
      rx_hold_req      = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero value, with and without prefixes
      directed.push_back(make_req(0, 10, 0, 0, 7'b0000000));
      directed.push_back(make_req(0, 8, 0, 0, 7'b0000010));
      directed.push_back(make_req(0, 16, 0, 0, 7'b0000010));
      // Full-range unsigned, most negative and most positive signed
      directed.push_back(make_req(32'hFFFF_FFFF, 10, 0, 0, 7'b0000000));
      directed.push_back(make_req(32'h8000_0000, 10, 0, 0, 7'b0100000));
      directed.push_back(make_req(32'h7FFF_FFFF, 10, 0, 0, 7'b0110000));
      // Sign flag precedence and unsigned ignoring them
      directed.push_back(make_req(5, 10, 0, 0, 7'b0101000));
      directed.push_back(make_req(5, 10, 0, 0, 7'b0111000));
      directed.push_back(make_req(5, 10, 0, 0, 7'b0011000));
      // Hex and octal prefixes with padding
      directed.push_back(make_req(32'hDEAD_BEEF, 16, 0, 0, 7'b0000011));
      directed.push_back(make_req(32'h1234, 8, 12, 0, 7'b1000010));
      directed.push_back(make_req(32'h0000_00AB, 16, 20, 0, 7'b1110010));
      // Left justify overrides zero padding
      directed.push_back(make_req(42, 10, 10, 0, 7'b1000100));
      directed.push_back(make_req(32'hFFFF_FFF0, 10, 64, 10, 7'b1100100));
      // Bad bases at both ends of the field
      directed.push_back(make_req(123, 0, 5, 0, 7'b0000000));
      directed.push_back(make_req(123, 1, 0, 0, 7'b0000000));
      directed.push_back(make_req(123, 37, 0, 0, 7'b0000000));
      directed.push_back(make_req(32'hFFFF_FFFF, 63, 127, 63, 7'b1111111));
      // Digit string extremes: longest in base 2, shortest in base 36
      directed.push_back(make_req(32'hFFFF_FFFF, 2, 64, 0, 7'b0000000));
      directed.push_back(make_req(32'hFFFF_FFFF, 36, 0, 0, 7'b0000001));
      // Width and precision saturation, text at its full length
      directed.push_back(make_req(-7, 10, 127, 0, 7'b0100000));
      directed.push_back(make_req(32'hFFFF_FF00, 16, 0, 63, 7'b0100011));
      // Prefix flag in a base without a prefix
      directed.push_back(make_req(100, 3, 0, 0, 7'b0000010));

      foreach (directed[i])
         send_item(directed[i]);
      drain_text();

      // Random phases: mixed gaps, steady sender, steady receiver, no gaps
      for (int phase = 0; phase < 4; phase++) begin
         tx_quiet = (phase == 1) || (phase == 3);
         rx_quiet = (phase == 2) || (phase == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 0 && n == 20)
               rx_hold_req = 1'b1;
            send_item(random_req());
         end
         drain_text();
      end

      repeat (SETTLE_WAIT) @(posedge clock);
      if (ledger.outstanding() != 0) begin
         $display("%0t: %0d characters expected, none arrived", $time, ledger.outstanding());
         ledger.errors++;
      end

      $display("Ran %0d requests (%0d with a bad base), checked %0d characters, longest %0d.",
               ledger.requests, ledger.bad_requests, ledger.chars_seen, ledger.longest);
      $display("Included a long output stall, drained pauses and gap-free stretches.");
      if (ledger.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
